### src/frame_deframer_checker_unit_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FRAME_DEFRAMER_CHECKER_UNIT_MACROS_SVH
`define FRAME_DEFRAMER_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define FDC_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FDC_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define FDC_ASSERT_IMP(lbl, ant, cons)
`define FDC_ASSERT_NXT(lbl, ant, cons)

`endif

`endif

### src/fdc_pkg.sv
`default_nettype none

package fdc_pkg;

  // Largest payload a frame may announce.
  localparam int MAX_PAYLOAD = 256;

  // Flag, sequence (2), acknowledge (2) and length (2) bytes.
  localparam int HDR_BYTES = 7;

  // Byte position counts up to the second checksum byte of the longest frame.
  localparam int POS_W = $clog2(HDR_BYTES + MAX_PAYLOAD + 2);

  // Width used to compare positions against header plus length.
  localparam int EXT_W = 17;

  localparam logic [7:0] FLAG_MASK = 8'b1111_1100;
  localparam logic [7:0] FLAG_TAG  = 8'b1100_1100;
  localparam logic [7:0] FLAG_ACK  = 8'b0000_0001;
  localparam logic [7:0] FLAG_FIN  = 8'b0000_0010;

  // Header byte positions.
  localparam logic [POS_W-1:0] POS_FLAG    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ACK_HI  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ACK_LO  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HDR_BYTES + MAX_PAYLOAD + 1);

  localparam logic [EXT_W-1:0] LEN_LIMIT = EXT_W'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FTYPE_DATA = 2'd0,
    FTYPE_ACK  = 2'd1,
    FTYPE_FIN  = 2'd2
  } frame_type_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FLAG     = 2'd1,
    ERR_LENGTH   = 2'd2,
    ERR_CHECKSUM = 2'd3
  } error_code_t;

  // The acknowledge bit wins over the finish bit.
  function automatic frame_type_t type_of(input logic [7:0] flag);
    frame_type_t t;
    if ((flag & FLAG_ACK) != 8'd0) begin
      t = FTYPE_ACK;
    end else if ((flag & FLAG_FIN) != 8'd0) begin
      t = FTYPE_FIN;
    end else begin
      t = FTYPE_DATA;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### src/frame_deframer_checker_unit.sv
// Channel  | Dir | Signals                        | Content
// ---------+-----+--------------------------------+------------------------------------
// s        | in  | s_tvalid s_tready s_tdata[7:0] | one received link byte per beat
// m        | out | m_tvalid m_tready m_tdata[63:0]| payload byte or end-of-frame report
//          |     | m_tuser[1:0]                   | kind of the beat
//
// One link byte is taken per clock whenever the result register is empty or being
// drained in the same cycle; the parse state and checksum update in that cycle.
// A byte that produces a result shows it on m in the cycle after it is accepted.
// Backpressure on m stalls s only while the single result register is full and
// not being taken; s_tready follows m_tready combinationally.
// rst is synchronous and active high; it clears the parser to expect a flag byte.
`default_nettype none

`include "frame_deframer_checker_unit_macros.svh"

module frame_deframer_checker_unit
  import fdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [7:0] payload_byte, [9:8] frame_type,
                                      // [25:10] seq_number, [41:26] ack_number,
                                      // [57:42] payload_length, [59:58] error_code,
                                      // [63:60] zero
  output logic [1:0]       m_tuser    // [1:0] kind
);

  // Parser state. The header fields are kept until the frame ends so that the
  // end-of-frame report can carry them.
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       flag_value, flag_value_next;
  logic [15:0]      seq_field, seq_field_next;
  logic [15:0]      ack_field, ack_field_next;
  logic [15:0]      length_field, length_field_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       sum_high_byte, sum_high_byte_next;

  // Result register.
  logic             out_valid;
  kind_t            out_kind, out_kind_next;
  logic [7:0]       out_payload, out_payload_next;
  frame_type_t      out_type, out_type_next;
  logic [15:0]      out_seq, out_seq_next;
  logic [15:0]      out_ack, out_ack_next;
  logic [15:0]      out_len, out_len_next;
  error_code_t      out_err, out_err_next;
  logic             emit;

  logic             accept;
  logic [7:0]       rx_byte;
  logic [15:0]      sum_added;
  logic [15:0]      len_full;
  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] data_end;
  logic [15:0]      got_sum;

  assign rx_byte  = s_tdata;
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Checksum step: rotate right by one, then add the byte modulo 2^16.
  assign sum_added = {running_sum[0], running_sum[15:1]} + {8'd0, rx_byte};

  // Length as it stands once its low byte arrives.
  assign len_full = {length_field[15:8], rx_byte};

  // Position of the first checksum byte.
  assign pos_ext  = EXT_W'(pos);
  assign data_end = EXT_W'(HDR_BYTES) + {1'b0, length_field};

  assign got_sum = {sum_high_byte, rx_byte};

  always_comb begin
    pos_next           = pos;
    flag_value_next    = flag_value;
    seq_field_next     = seq_field;
    ack_field_next     = ack_field;
    length_field_next  = length_field;
    running_sum_next   = running_sum;
    sum_high_byte_next = sum_high_byte;

    emit             = 1'b0;
    out_kind_next    = KIND_PAYLOAD;
    out_payload_next = 8'd0;
    out_type_next    = type_of(flag_value);
    out_seq_next     = seq_field;
    out_ack_next     = ack_field;
    out_len_next     = length_field;
    out_err_next     = ERR_NONE;

    if (pos == POS_FLAG) begin
      if ((rx_byte & FLAG_MASK) != FLAG_TAG) begin
        // Bad tag: report with cleared header and look for a flag again.
        emit          = 1'b1;
        out_kind_next = KIND_ERROR;
        out_err_next  = ERR_FLAG;
        out_type_next = FTYPE_DATA;
        out_seq_next  = 16'd0;
        out_ack_next  = 16'd0;
        out_len_next  = 16'd0;
      end else begin
        flag_value_next  = rx_byte;
        running_sum_next = sum_added;
        pos_next         = pos + POS_W'(1);
      end
    end else if (pos < POS_HDR_END) begin
      running_sum_next = sum_added;
      pos_next         = pos + POS_W'(1);
      unique case (pos)
        POS_SEQ_HI: seq_field_next    = {rx_byte, 8'd0};
        POS_SEQ_LO: seq_field_next    = {seq_field[15:8], rx_byte};
        POS_ACK_HI: ack_field_next    = {rx_byte, 8'd0};
        POS_ACK_LO: ack_field_next    = {ack_field[15:8], rx_byte};
        POS_LEN_HI: length_field_next = {rx_byte, 8'd0};
        default:    length_field_next = len_full;
      endcase
      if (pos == POS_LEN_LO && {1'b0, len_full} > LEN_LIMIT) begin
        emit          = 1'b1;
        out_kind_next = KIND_ERROR;
        out_err_next  = ERR_LENGTH;
        out_len_next  = len_full;
      end
    end else if (pos_ext < data_end) begin
      // Payload byte: pass it on at once.
      running_sum_next = sum_added;
      pos_next         = pos + POS_W'(1);
      emit             = 1'b1;
      out_payload_next = rx_byte;
      out_type_next    = FTYPE_DATA;
      out_seq_next     = 16'd0;
      out_ack_next     = 16'd0;
      out_len_next     = 16'd0;
    end else if (pos_ext == data_end) begin
      sum_high_byte_next = rx_byte;
      pos_next           = pos + POS_W'(1);
    end else begin
      emit = 1'b1;
      if (got_sum == running_sum) begin
        out_kind_next = KIND_ACCEPT;
      end else begin
        out_kind_next = KIND_ERROR;
        out_err_next  = ERR_CHECKSUM;
      end
    end

    // Any report ends the frame; the parser then expects a flag byte.
    if (emit && out_kind_next != KIND_PAYLOAD) begin
      pos_next           = POS_FLAG;
      flag_value_next    = 8'd0;
      seq_field_next     = 16'd0;
      ack_field_next     = 16'd0;
      length_field_next  = 16'd0;
      running_sum_next   = 16'd0;
      sum_high_byte_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= POS_FLAG;
      flag_value    <= 8'd0;
      seq_field     <= 16'd0;
      ack_field     <= 16'd0;
      length_field  <= 16'd0;
      running_sum   <= 16'd0;
      sum_high_byte <= 8'd0;
    end else if (accept) begin
      pos           <= pos_next;
      flag_value    <= flag_value_next;
      seq_field     <= seq_field_next;
      ack_field     <= ack_field_next;
      length_field  <= length_field_next;
      running_sum   <= running_sum_next;
      sum_high_byte <= sum_high_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind    <= out_kind_next;
      out_payload <= out_payload_next;
      out_type    <= out_type_next;
      out_seq     <= out_seq_next;
      out_ack     <= out_ack_next;
      out_len     <= out_len_next;
      out_err     <= out_err_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {4'd0, out_err, out_len, out_ack, out_seq, out_type, out_payload};

  // A payload beat carries nothing but the byte.
  `FDC_ASSERT_IMP(a_payload_clean, m_tvalid && m_tuser == KIND_PAYLOAD, m_tdata[63:8] == 56'd0)
  // An error code appears exactly on error reports.
  `FDC_ASSERT_IMP(a_err_matches_kind, m_tvalid, (m_tuser == KIND_ERROR) == (m_tdata[59:58] != 2'd0))
  // The position never runs past the last checksum byte of the longest frame.
  `FDC_ASSERT_IMP(a_pos_bound, 1'b1, pos <= POS_LAST)
  // Once the header is complete the stored length is within the limit.
  `FDC_ASSERT_IMP(a_len_bound, pos >= POS_HDR_END, {1'b0, length_field} <= LEN_LIMIT)
  // A report leaves the parser waiting for a flag byte.
  `FDC_ASSERT_NXT(a_report_restarts, accept && emit && out_kind_next != KIND_PAYLOAD, pos == POS_FLAG && running_sum == 16'd0)

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fdc_pkg::*;

  // Run shape. The random part stops once this many link bytes have gone in
  // after the directed rows; the last stretch of it runs with no idling at all.
  localparam int RAND_ITEMS   = 950;
  localparam int QUIET_TAIL   = 150;
  localparam int DIR_ROWS     = 28;
  localparam int SINK_HOLD    = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;

  // One result beat, unpacked into the fields that travel on m_tdata and m_tuser.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    frame_type_t ftype;
    logic [15:0] seq;
    logic [15:0] ack;
    logic [15:0] len;
    error_code_t err;
  } report_t;

  // One row of the directed table: the link byte, and where the outcome is
  // obvious, the report typed in by hand instead of taken from the predictor.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    report_t    rep;
  } stim_row_t;

  localparam report_t NO_REPORT = '0;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;

  // Reports the block still owes us, oldest first.
  report_t pending_reports[$];
  stim_row_t directed_rows[DIR_ROWS];

  int failures    = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;

  // Shared between the two sides: whether random idling is allowed right now,
  // and a one-shot request for the long receiver hold-off.
  bit gaps_on       = 1'b1;
  bit sink_hold_req = 1'b0;

  frame_deframer_checker_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deframer predictor. It keeps its own copy of the parse state and walks it
  // one link byte at a time, exactly as the block is meant to.
  // ---------------------------------------------------------------------------
  int unsigned pr_pos;
  logic [7:0]  pr_flag;
  logic [7:0]  pr_sum_hi;
  logic [15:0] pr_seq;
  logic [15:0] pr_ack;
  logic [15:0] pr_len;
  logic [15:0] pr_sum;

  // The running checksum rotates right by one, then adds the byte.
  function automatic logic [15:0] fold_byte(input logic [15:0] sum, input logic [7:0] b);
    return {sum[0], sum[15:1]} + {8'h00, b};
  endfunction

  function automatic void restart_parser();
    pr_pos    = 0;
    pr_flag   = '0;
    pr_sum_hi = '0;
    pr_seq    = '0;
    pr_ack    = '0;
    pr_len    = '0;
    pr_sum    = '0;
  endfunction

  // End-of-frame report built from whatever header fields are held right now.
  function automatic report_t frame_report(input kind_t k, input error_code_t e);
    report_t r;
    r = '0;
    r.kind = k;
    if ((pr_flag & FLAG_ACK) != 8'd0) begin
      r.ftype = FTYPE_ACK;
    end else if ((pr_flag & FLAG_FIN) != 8'd0) begin
      r.ftype = FTYPE_FIN;
    end else begin
      r.ftype = FTYPE_DATA;
    end
    r.seq = pr_seq;
    r.ack = pr_ack;
    r.len = pr_len;
    r.err = e;
    return r;
  endfunction

  // Returns 1 when the byte causes a result beat, and that beat in r.
  function automatic bit deframe_byte(input logic [7:0] b, output report_t r);
    int unsigned frame_end;
    bit produced;
    frame_end = HDR_BYTES + pr_len;
    produced  = 1'b0;
    r = '0;
    if (pr_pos == POS_FLAG) begin
      if ((b & FLAG_MASK) != FLAG_TAG) begin
        // A bad tag reports with all header fields cleared.
        restart_parser();
        r = frame_report(KIND_ERROR, ERR_FLAG);
        produced = 1'b1;
      end else begin
        pr_flag = b;
        pr_sum  = fold_byte(pr_sum, b);
        pr_pos  = 1;
      end
    end else if (pr_pos < HDR_BYTES) begin
      pr_sum = fold_byte(pr_sum, b);
      case (pr_pos)
        POS_SEQ_HI: pr_seq[15:8] = b;
        POS_SEQ_LO: pr_seq[7:0]  = b;
        POS_ACK_HI: pr_ack[15:8] = b;
        POS_ACK_LO: pr_ack[7:0]  = b;
        POS_LEN_HI: pr_len[15:8] = b;
        default:    pr_len[7:0]  = b;
      endcase
      if (pr_pos == POS_LEN_LO && pr_len > MAX_PAYLOAD) begin
        r = frame_report(KIND_ERROR, ERR_LENGTH);
        restart_parser();
        produced = 1'b1;
      end else begin
        pr_pos++;
      end
    end else if (pr_pos < frame_end) begin
      pr_sum    = fold_byte(pr_sum, b);
      pr_pos++;
      r.kind    = KIND_PAYLOAD;
      r.payload = b;
      produced  = 1'b1;
    end else if (pr_pos == frame_end) begin
      pr_sum_hi = b;
      pr_pos++;
    end else begin
      if ({pr_sum_hi, b} == pr_sum) begin
        r = frame_report(KIND_ACCEPT, ERR_NONE);
      end else begin
        r = frame_report(KIND_ERROR, ERR_CHECKSUM);
      end
      restart_parser();
      produced = 1'b1;
    end
    return produced;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. One link byte per call; the expectation is recorded at the
  // edge where the beat is taken. A random gap may come before the beat.
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic typed, input report_t typed_rep);
    report_t r;
    bit produced;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    produced = deframe_byte(b, r);
    if (typed) begin
      pending_reports.push_back(typed_rep);
    end else if (produced) begin
      pending_reports.push_back(r);
    end
    bytes_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. Mostly ready, with random stall bursts, and once a long
  // hold-off counted here so the single result register fills and the block
  // has to stall its input while the sender keeps offering bytes.
  // ---------------------------------------------------------------------------
  initial begin : sink
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking. Every taken beat is matched against the oldest pending
  // report, field by field.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing pending: kind 0x%0h, tdata 0x%0h", m_tuser, m_tdata);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind",           16'(want.kind),    16'(m_tuser));
        check_field("payload_byte",   16'(want.payload), 16'(m_tdata[7:0]));
        check_field("frame_type",     16'(want.ftype),   16'(m_tdata[9:8]));
        check_field("seq_number",     want.seq,          m_tdata[25:10]);
        check_field("ack_number",     want.ack,          m_tdata[41:26]);
        check_field("payload_length", want.len,          m_tdata[57:42]);
        check_field("error_code",     16'(want.err),     16'(m_tdata[59:58]));
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then random frames.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  fb[$];
    logic [15:0] csum;
    logic [15:0] plen;
    logic [15:0] seq_v;
    logic [15:0] ack_v;
    int frame_idx;
    int choice;
    int cut;
    bit hold_done;
    bit drain_done;

    frame_idx  = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    restart_parser();

    directed_rows = '{
      // Bad flag tags at both ends of the byte range: an error report at once,
      // every header field zero.
      '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, FTYPE_DATA, 16'h0000, 16'h0000, 16'h0000, ERR_FLAG}},
      '{8'hFF, 1'b1, '{KIND_ERROR, 8'h00, FTYPE_DATA, 16'h0000, 16'h0000, 16'h0000, ERR_FLAG}},
      // Finish frame with zero length: checksum follows the header directly.
      // Flag 0xCE then six zero bytes leaves the sum at 0x3803.
      '{8'hCE, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h38, 1'b0, NO_REPORT},
      '{8'h03, 1'b1, '{KIND_ACCEPT, 8'h00, FTYPE_FIN, 16'h0000, 16'h0000, 16'h0000, ERR_NONE}},
      // Both type bits set, all header fields at their maximum: the length is
      // too long, and the acknowledge bit wins the type.
      '{8'hCF, 1'b0, NO_REPORT},
      '{8'hFF, 1'b0, NO_REPORT},
      '{8'hFF, 1'b0, NO_REPORT},
      '{8'hFF, 1'b0, NO_REPORT},
      '{8'hFF, 1'b0, NO_REPORT},
      '{8'hFF, 1'b0, NO_REPORT},
      '{8'hFF, 1'b1, '{KIND_ERROR, 8'h00, FTYPE_ACK, 16'hFFFF, 16'hFFFF, 16'hFFFF, ERR_LENGTH}},
      // Data frame with one payload byte and a zero checksum, which is wrong
      // (the sum is 0x6101). The payload byte still goes out first.
      '{8'hCC, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h02, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, NO_REPORT},
      '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, FTYPE_DATA, 16'h0000, 16'h0000, 16'h0000, ERR_NONE}},
      '{8'h00, 1'b0, NO_REPORT},
      '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, FTYPE_DATA, 16'h0001, 16'h0002, 16'h0001,
                       ERR_CHECKSUM}}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].rep);
    end

    // Random part. Most of it is well-formed frames with random headers and
    // payloads, so the parser gets all the way to the checksum; the rest is
    // line noise, over-long lengths, corrupted checksums and cut-off frames.
    while (bytes_sent < DIR_ROWS + RAND_ITEMS) begin
      choice  = $urandom_range(0, 99);
      gaps_on = (bytes_sent < DIR_ROWS + RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);

      if (!hold_done && bytes_sent > 300) begin
        hold_done     = 1'b1;
        sink_hold_req = 1'b1;
      end

      // Once, let the block run completely dry before going on.
      if (!drain_done && bytes_sent > 600) begin
        drain_done = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
      end

      if (choice < 8) begin
        repeat ($urandom_range(1, 3)) offer_byte(8'($urandom), 1'b0, NO_REPORT);
      end else begin
        // A couple of frames pin the length to the limit and just past it.
        if (frame_idx == 5) begin
          plen = 16'(MAX_PAYLOAD + 1);
        end else if (frame_idx == 12) begin
          plen = 16'(MAX_PAYLOAD);
        end else if (choice < 14) begin
          plen = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
        end else if (choice < 20) begin
          plen = 16'($urandom_range(13, 80));
        end else begin
          plen = 16'($urandom_range(0, 12));
        end
        seq_v = 16'($urandom);
        ack_v = 16'($urandom);

        fb.delete();
        fb.push_back(FLAG_TAG | 8'($urandom_range(0, 3)));
        fb.push_back(seq_v[15:8]);
        fb.push_back(seq_v[7:0]);
        fb.push_back(ack_v[15:8]);
        fb.push_back(ack_v[7:0]);
        fb.push_back(plen[15:8]);
        fb.push_back(plen[7:0]);

        // An over-long frame ends at its header; otherwise add payload and sum.
        if (plen <= MAX_PAYLOAD) begin
          repeat (plen) fb.push_back(8'($urandom));
          csum = '0;
          foreach (fb[i]) csum = fold_byte(csum, fb[i]);
          if (choice >= 20 && choice < 28) begin
            csum ^= 16'($urandom_range(1, 65535));
          end
          fb.push_back(csum[15:8]);
          fb.push_back(csum[7:0]);
        end

        cut = fb.size();
        if (choice >= 28 && choice < 33) begin
          cut = $urandom_range(1, fb.size() - 1);
        end
        for (int i = 0; i < cut; i++) begin
          offer_byte(fb[i], 1'b0, NO_REPORT);
        end
        frame_idx++;
      end
    end

    // Stop offering, collect everything still owed, then give the block a few
    // more cycles to show any beat it should not produce.
    gaps_on = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/fdc_pkg.sv
src/frame_deframer_checker_unit.sv
tb/testbench.sv
